// ===== rtl/core/crfd_pkg.sv =====
// Shared constants and types for the Catmull-Rom forward-differencing block.
// Holds the step count, the derived fixed-point widths, the reciprocal and the divider type.
// Depends on nothing; used by crfd_div and catmull_rom_forward_diff.
package crfd_pkg;

  localparam int STEPS = 10;
  localparam int DEN   = 2 * STEPS * STEPS * STEPS;
  localparam int RW    = $clog2(DEN);
  localparam int DW    = 36 + 2 * $clog2(STEPS);
  localparam int NW    = $clog2(STEPS + 1);

  // The divider takes the dividend magnitude in slices of LW bits, one per cycle.
  localparam int LW    = 16;
  localparam int NL    = (DW + LW - 1) / LW;
  localparam int UW    = NL * LW;
  localparam int CW    = $clog2(NL + 2);
  localparam int RSH   = DW - 1 + RW;
  localparam int QW    = DW - RW;
  localparam int PW    = 2 * DW;

  localparam longint RECIP = ((longint'(1) << RSH) + longint'(DEN) - 1) / longint'(DEN);

  localparam logic [RW:0]   DEN_W    = DEN[RW:0];
  localparam logic [RW-1:0] DEN_M1   = DEN_W[RW-1:0] - 1'b1;
  localparam logic [RW-1:0] HALF_DEN = DEN_W[RW:1];
  localparam logic [DW-1:0] RECIP_W  = RECIP[DW-1:0];

  // A value held as q * DEN + r with 0 <= r < DEN.
  typedef struct packed {
    logic signed [DW-1:0] q;
    logic [RW-1:0]        r;
  } mr_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic signed [DW-1:0] quo;
    logic [RW-1:0]        rem;
  } div_res_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOAD = 4'b0010,
    ST_WAIT = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

endpackage

// ===== rtl/core/crfd_div.sv =====
// Floor division of a signed word by the constant difference scale through a stored reciprocal.
// One shared multiplier takes a 16-bit slice of the magnitude per cycle, then forms the remainder.
// Depends on crfd_pkg.
module crfd_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [crfd_pkg::DW-1:0]     dividend,
  output crfd_pkg::div_res_t                 res
);

  localparam int DW  = crfd_pkg::DW;
  localparam int RW  = crfd_pkg::RW;
  localparam int CW  = crfd_pkg::CW;
  localparam int LW  = crfd_pkg::LW;
  localparam int NL  = crfd_pkg::NL;
  localparam int UW  = crfd_pkg::UW;
  localparam int QW  = crfd_pkg::QW;
  localparam int PW  = crfd_pkg::PW;
  localparam int RSH = crfd_pkg::RSH;

  logic             busy;
  logic             done;
  logic             neg;
  logic [UW-1:0]    sh;
  logic [RW-1:0]    u_lo;
  logic [PW-1:0]    acc;
  logic [RW-1:0]    rem;
  logic [CW-1:0]    cnt;
  logic [DW-1:0]    mag;
  logic [QW-1:0]    quo;
  logic [LW-1:0]    mul_a;
  logic [DW-1:0]    mul_b;
  logic [LW+DW-1:0] prod;

  // Negative dividends are divided as their complement, which is never negative.
  always_comb begin
    mag = dividend[DW-1] ? ~dividend : dividend;
    quo = acc[RSH +: QW];
    if (cnt == CW'(1)) begin
      mul_a = LW'(quo[RW-1:0]);
      mul_b = DW'(crfd_pkg::DEN_W);
    end else begin
      mul_a = sh[UW-1 -: LW];
      mul_b = crfd_pkg::RECIP_W;
    end
    prod = mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NL + 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg  <= dividend[DW-1];
      sh   <= UW'(mag);
      u_lo <= mag[RW-1:0];
      acc  <= '0;
    end else if (busy) begin
      if (cnt == CW'(1)) begin
        rem <= u_lo - prod[RW-1:0];
      end else begin
        acc <= (acc << LW) + PW'(prod);
        sh  <= sh << LW;
      end
    end
  end

  always_comb begin
    res.busy = busy;
    res.done = done;
    res.quo  = neg ? ~DW'(quo) : DW'(quo);
    res.rem  = neg ? (crfd_pkg::DEN_M1 - rem) : rem;
  end

`ifndef SYNTHESIS
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    res.done |-> res.rem <= crfd_pkg::DEN_M1)
    else $error("Divider remainder is not below the scale.");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("Divider reported a result while still busy.");

  a_busy_count: assert property (@(posedge clk) disable iff (rst)
    busy |-> (cnt != '0) && (cnt <= CW'(NL + 1)))
    else $error("Divider cycle count is out of range.");
`endif

endmodule

// ===== rtl/core/catmull_rom_forward_diff.sv =====
// Top level of the Catmull-Rom spline evaluator with forward differencing.
// Holds the point window, the sequencer, the difference registers and the output register.
// Depends on crfd_pkg and crfd_div.
//
// Control points enter one item at a time; once four are held, each point yields STEPS+1
// vertices of the segment between the second and third window points, the first flagged
// strip_start and the last strip_end, with new_curve emptying the window first. A point
// that completes no segment leaves in_ready high. A point that completes a segment keeps
// in_ready low from its acceptance until its last vertex is produced: the six
// forward-difference terms are each split into whole and fractional parts by one shared
// divider by the constant scale, which multiplies by a stored reciprocal one 16-bit slice
// per cycle, then one vertex is produced per cycle while the output register is free. The
// output register lets a new point be taken while the last vertex still waits to be
// collected.
module catmull_rom_forward_diff (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic               new_curve,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] vertex_x,
  output logic signed [31:0] vertex_y,
  output logic               strip_start,
  output logic               strip_end
);

  localparam int DW    = crfd_pkg::DW;
  localparam int RW    = crfd_pkg::RW;
  localparam int NW    = crfd_pkg::NW;
  localparam int STEPS = crfd_pkg::STEPS;

  localparam logic signed [DW-1:0] SAT_HI = DW'(32'sh7FFF_FFFF);
  localparam logic signed [DW-1:0] SAT_LO = -SAT_HI - 1;

  crfd_pkg::state_t    state;
  logic signed [31:0]  win_x [4];
  logic signed [31:0]  win_y [4];
  logic [2:0]          held;
  logic [2:0]          held_base;
  logic [2:0]          held_next;
  logic [2:0]          div_k;
  logic [NW-1:0]       step_n;
  crfd_pkg::mr_t       fx [4];
  crfd_pkg::mr_t       fy [4];
  logic                accept;
  logic                out_free;
  logic                emit;
  logic                div_start;
  logic signed [DW-1:0] dividend;
  crfd_pkg::div_res_t  div_res;

  logic signed [DW-1:0] w0, w1, w2, w3;
  logic signed [DW-1:0] a2, b2, c2;

  function automatic crfd_pkg::mr_t mr_add(crfd_pkg::mr_t a, crfd_pkg::mr_t b);
    logic [RW:0]   s;
    logic [RW:0]   d;
    crfd_pkg::mr_t res;
    s = {1'b0, a.r} + {1'b0, b.r};
    d = s - crfd_pkg::DEN_W;
    if (s >= crfd_pkg::DEN_W) begin
      res.r = d[RW-1:0];
      res.q = a.q + b.q + 1;
    end else begin
      res.r = s[RW-1:0];
      res.q = a.q + b.q;
    end
    return res;
  endfunction

  // Rounds to nearest with halves upwards, then clamps to the 32-bit range.
  function automatic logic signed [31:0] to_q16(crfd_pkg::mr_t v);
    logic signed [DW-1:0] t;
    logic signed [31:0]   res;
    t = v.q + DW'(v.r >= crfd_pkg::HALF_DEN);
    priority if (t > SAT_HI) begin
      res = 32'sh7FFF_FFFF;
    end else if (t < SAT_LO) begin
      res = 32'sh8000_0000;
    end else begin
      res = t[31:0];
    end
    return res;
  endfunction

  assign in_ready  = (state == crfd_pkg::ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign emit      = (state == crfd_pkg::ST_EMIT) && out_free;
  assign div_start = (state == crfd_pkg::ST_LOAD);

  always_comb begin
    held_base = new_curve ? 3'd0 : held;
    held_next = (held_base == 3'd4) ? 3'd4 : held_base + 3'd1;
  end

  always_comb begin
    if (div_k >= 3'd3) begin
      w0 = DW'(win_y[0]);
      w1 = DW'(win_y[1]);
      w2 = DW'(win_y[2]);
      w3 = DW'(win_y[3]);
    end else begin
      w0 = DW'(win_x[0]);
      w1 = DW'(win_x[1]);
      w2 = DW'(win_x[2]);
      w3 = DW'(win_x[3]);
    end
    a2 = -w0 + w1 * 3 - w2 * 3 + w3;
    b2 = w0 * 2 - w1 * 5 + w2 * 4 - w3;
    c2 = w2 - w0;
    unique case (div_k)
      3'd0, 3'd3: dividend = a2 + b2 * STEPS + c2 * (STEPS * STEPS);
      3'd1, 3'd4: dividend = a2 * 6 + b2 * (2 * STEPS);
      default:    dividend = a2 * 6;
    endcase
  end

  crfd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .res      (div_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= crfd_pkg::ST_IDLE;
      held      <= 3'd0;
      div_k     <= 3'd0;
      step_n    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        crfd_pkg::ST_IDLE: begin
          if (accept) begin
            held <= held_next;
            if (held_next == 3'd4) begin
              div_k <= 3'd0;
              state <= crfd_pkg::ST_LOAD;
            end
          end
        end
        crfd_pkg::ST_LOAD: begin
          state <= crfd_pkg::ST_WAIT;
        end
        crfd_pkg::ST_WAIT: begin
          if (div_res.done) begin
            if (div_k == 3'd5) begin
              step_n <= '0;
              state  <= crfd_pkg::ST_EMIT;
            end else begin
              div_k <= div_k + 3'd1;
              state <= crfd_pkg::ST_LOAD;
            end
          end
        end
        crfd_pkg::ST_EMIT: begin
          if (out_free) begin
            step_n <= step_n + 1'b1;
            if (step_n == NW'(STEPS)) begin
              state <= crfd_pkg::ST_IDLE;
            end
          end
        end
        default: begin
          state <= crfd_pkg::ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      win_x[0] <= win_x[1];
      win_x[1] <= win_x[2];
      win_x[2] <= win_x[3];
      win_x[3] <= point_x;
      win_y[0] <= win_y[1];
      win_y[1] <= win_y[2];
      win_y[2] <= win_y[3];
      win_y[3] <= point_y;
    end
    if ((state == crfd_pkg::ST_WAIT) && div_res.done) begin
      unique case (div_k)
        3'd0:    fx[1] <= '{q: div_res.quo, r: div_res.rem};
        3'd1:    fx[2] <= '{q: div_res.quo, r: div_res.rem};
        3'd2:    fx[3] <= '{q: div_res.quo, r: div_res.rem};
        3'd3:    fy[1] <= '{q: div_res.quo, r: div_res.rem};
        3'd4:    fy[2] <= '{q: div_res.quo, r: div_res.rem};
        default: fy[3] <= '{q: div_res.quo, r: div_res.rem};
      endcase
      if (div_k == 3'd5) begin
        fx[0] <= '{q: DW'(win_x[1]), r: '0};
        fy[0] <= '{q: DW'(win_y[1]), r: '0};
      end
    end
    if (emit) begin
      vertex_x    <= to_q16(fx[0]);
      vertex_y    <= to_q16(fy[0]);
      strip_start <= (step_n == '0);
      strip_end   <= (step_n == NW'(STEPS));
      fx[0]       <= mr_add(fx[0], fx[1]);
      fx[1]       <= mr_add(fx[1], fx[2]);
      fx[2]       <= mr_add(fx[2], fx[3]);
      fy[0]       <= mr_add(fy[0], fy[1]);
      fy[1]       <= mr_add(fy[1], fy[2]);
      fy[2]       <= mr_add(fy[2], fy[3]);
    end
  end

`ifndef SYNTHESIS
  a_div_idle_on_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_res.busy)
    else $error("Division started while the divider was busy.");

  a_frac_range: assert property (@(posedge clk) disable iff (rst)
    (state == crfd_pkg::ST_EMIT) |->
      (fx[0].r < crfd_pkg::DEN_W) && (fy[0].r < crfd_pkg::DEN_W))
    else $error("Vertex fraction is out of range.");

  a_last_vertex: assert property (@(posedge clk) disable iff (rst)
    (out_valid && strip_end) |-> (state != crfd_pkg::ST_EMIT) || (step_n == '0))
    else $error("Vertex produced after the last one of a segment.");

  a_full_window: assert property (@(posedge clk) disable iff (rst)
    (accept && !new_curve && (held == 3'd4)) |=> (state == crfd_pkg::ST_LOAD))
    else $error("Point with a full window did not start a segment.");
`endif

endmodule

// ===== tb/catmull_rom_forward_diff_tb.sv =====
// Self-checking testbench for catmull_rom_forward_diff: streams control points into the
// block, predicts every curve vertex and compares each returned vertex field by field.
// Depends on crfd_pkg for the step count and on the catmull_rom_forward_diff RTL.
`timescale 1ns / 100ps

module catmull_rom_forward_diff_tb;

  localparam int     SEG_STEPS = crfd_pkg::STEPS;
  localparam longint SEG_DEN   = 2 * SEG_STEPS * SEG_STEPS * SEG_STEPS;
  localparam longint LIMIT_NS  = 24_000_000;
  localparam int     TAIL_CYCLES = 320;
  localparam int     RANDOM_POINTS = 500;

  typedef logic signed [31:0] q16_t;
  typedef longint quad_t [4];

  localparam q16_t Q16_MAX = 32'sh7FFF_FFFF;
  localparam q16_t Q16_MIN = 32'sh8000_0000;

  typedef struct {
    q16_t x;
    q16_t y;
    logic nc;
  } ctrl_point_t;

  typedef struct {
    q16_t x;
    q16_t y;
    logic first;
    logic last;
  } vertex_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  q16_t point_x = '0;
  q16_t point_y = '0;
  logic new_curve = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  q16_t vertex_x;
  q16_t vertex_y;
  logic strip_start;
  logic strip_end;

  ctrl_point_t pending_points[$];
  vertex_t     expected_vertices[$];

  longint win_x[4];
  longint win_y[4];
  int     held_points;

  int total_points;
  int points_taken;
  int curves_restarted;
  int segments_expected;
  int vertices_checked;
  int clamped_coords;
  int errors;
  int in_gap;
  int out_gap;

  catmull_rom_forward_diff DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .point_x     (point_x),
    .point_y     (point_y),
    .new_curve   (new_curve),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .vertex_x    (vertex_x),
    .vertex_y    (vertex_y),
    .strip_start (strip_start),
    .strip_end   (strip_end)
  );

  always #6 clk = ~clk;

  function automatic void add_point(input q16_t x, input q16_t y, input logic nc);
    ctrl_point_t p;
    p.x = x;
    p.y = y;
    p.nc = nc;
    pending_points.push_back(p);
  endfunction

  function automatic q16_t pick_coord();
    int r;
    r = $urandom_range(0, 19);
    if (r < 3) begin
      unique case ($urandom_range(0, 4))
        0: return Q16_MAX;
        1: return Q16_MIN;
        2: return '0;
        3: return -32'sd1;
        default: return 32'sd1;
      endcase
    end else if (r < 8) begin
      return $urandom;
    end
    return $signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
  endfunction

  // Idling is switched off in every third stretch of items and near the end of the run.
  function automatic bit idle_enabled();
    return pending_points.size() > 40 && ((points_taken / 40) % 3) != 1;
  endfunction

  function automatic void diff_terms(input quad_t p, output quad_t f);
    longint a2, b2, c2, s;
    s = SEG_STEPS;
    a2 = -p[0] + 3 * p[1] - 3 * p[2] + p[3];
    b2 = 2 * p[0] - 5 * p[1] + 4 * p[2] - p[3];
    c2 = -p[0] + p[2];
    f[0] = SEG_DEN * p[1];
    f[1] = a2 + b2 * s + c2 * s * s;
    f[2] = 6 * a2 + 2 * b2 * s;
    f[3] = 6 * a2;
  endfunction

  // Rounds num / SEG_DEN to the nearest value, halves upwards, then clamps to 32 bits.
  function automatic q16_t round_sat(input longint num);
    longint t, q;
    t = 2 * num + SEG_DEN;
    q = t / (2 * SEG_DEN);
    if ((t % (2 * SEG_DEN)) != 0 && t < 0) q = q - 1;
    if (q > longint'(Q16_MAX)) begin
      q = longint'(Q16_MAX);
      clamped_coords++;
    end else if (q < longint'(Q16_MIN)) begin
      q = longint'(Q16_MIN);
      clamped_coords++;
    end
    return q[31:0];
  endfunction

  task automatic predict_point(input q16_t px, input q16_t py, input logic nc);
    quad_t fx, fy;
    vertex_t v;
    if (nc) begin
      for (int i = 0; i < 4; i++) begin
        win_x[i] = 0;
        win_y[i] = 0;
      end
      held_points = 0;
      curves_restarted++;
    end
    for (int i = 0; i < 3; i++) begin
      win_x[i] = win_x[i + 1];
      win_y[i] = win_y[i + 1];
    end
    win_x[3] = longint'(px);
    win_y[3] = longint'(py);
    if (held_points < 4) held_points++;
    if (held_points < 4) return;
    segments_expected++;
    diff_terms(win_x, fx);
    diff_terms(win_y, fy);
    for (int n = 0; n <= SEG_STEPS; n++) begin
      if (n > 0) begin
        for (int k = 0; k < 3; k++) begin
          fx[k] = fx[k] + fx[k + 1];
          fy[k] = fy[k] + fy[k + 1];
        end
      end
      v.x = round_sat(fx[0]);
      v.y = round_sat(fy[0]);
      v.first = (n == 0);
      v.last = (n == SEG_STEPS);
      expected_vertices.push_back(v);
    end
  endtask

  always @(posedge clk) begin : drive_points
    logic hold;
    ctrl_point_t p;
    if (rst) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      hold = in_valid && !in_ready;
      if (in_valid && in_ready) begin
        predict_point(point_x, point_y, new_curve);
        points_taken++;
      end
      if (!hold) begin
        if (in_gap > 0 || pending_points.size() == 0) begin
          if (in_gap > 0) in_gap--;
          in_valid <= 1'b0;
        end else begin
          p = pending_points.pop_front();
          point_x <= p.x;
          point_y <= p.y;
          new_curve <= p.nc;
          in_valid <= 1'b1;
          if (idle_enabled() && $urandom_range(0, 3) == 0) in_gap = $urandom_range(1, 7);
        end
      end
    end
  end

  always @(posedge clk) begin : check_vertices
    vertex_t want;
    if (rst) begin
      out_ready <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_valid && out_ready) begin
        vertices_checked++;
        if (expected_vertices.size() == 0) begin
          errors++;
          if (errors <= 200)
            $display("%0t: unexpected vertex x=%0d y=%0d start=%0b end=%0b", $time,
                     vertex_x, vertex_y, strip_start, strip_end);
        end else begin
          want = expected_vertices.pop_front();
          if (vertex_x !== want.x || vertex_y !== want.y ||
              strip_start !== want.first || strip_end !== want.last) begin
            errors++;
            if (errors <= 200)
              $display("%0t: expected x=%0d y=%0d s=%0b e=%0b, got x=%0d y=%0d s=%0b e=%0b",
                       $time, want.x, want.y, want.first, want.last,
                       vertex_x, vertex_y, strip_start, strip_end);
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else if (idle_enabled() && $urandom_range(0, 4) == 0) begin
        out_gap = $urandom_range(1, 7) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : run_sequence
    int run_len;
    int target;

    // Extreme corners, then a segment whose bulge runs past both Q16.16 limits.
    add_point(Q16_MIN, Q16_MIN, 1'b1);
    add_point(Q16_MAX, Q16_MAX, 1'b0);
    add_point(Q16_MAX, Q16_MIN, 1'b0);
    add_point(Q16_MIN, Q16_MAX, 1'b0);
    add_point('0, '0, 1'b0);
    add_point(-32'sd1, -32'sd1, 1'b0);
    add_point('0, '0, 1'b1);
    add_point(Q16_MAX, Q16_MIN, 1'b0);
    add_point(Q16_MAX, Q16_MIN, 1'b0);
    add_point('0, '0, 1'b0);
    add_point(Q16_MIN, Q16_MAX, 1'b0);
    add_point(Q16_MIN, Q16_MAX, 1'b0);
    // A curve restarted before it reaches four points.
    add_point(32'sh0001_0000, -32'sh0001_0000, 1'b1);
    add_point(32'sh0003_0000, 32'sh0002_0000, 1'b0);
    add_point(32'sd5, -32'sd7, 1'b1);
    add_point(32'sd1, 32'sd2, 1'b0);
    add_point(32'sd3, 32'sd4, 1'b0);
    add_point(32'sh0001_8000, -32'sh0000_8000, 1'b0);

    target = pending_points.size() + RANDOM_POINTS;
    while (pending_points.size() < target) begin
      if ($urandom_range(0, 9) == 0) run_len = $urandom_range(1, 3);
      else run_len = $urandom_range(4, 24);
      for (int k = 0; k < run_len; k++)
        add_point(pick_coord(), pick_coord(), (k == 0) && ($urandom_range(0, 3) != 0));
    end
    total_points = pending_points.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (points_taken < total_points) @(posedge clk);
    while (expected_vertices.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d control points with %0d curve restarts and %0d segments.",
             points_taken, curves_restarted, segments_expected);
    $display("%0d vertices were checked, %0d expected coordinates clamped at the limits.",
             vertices_checked, clamped_coords);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $display("FAIL");
    $finish;
  end

endmodule

// ===== catmull_rom_forward_diff.f =====
rtl/core/crfd_pkg.sv
rtl/core/crfd_div.sv
rtl/core/catmull_rom_forward_diff.sv
tb/catmull_rom_forward_diff_tb.sv
